@@ rtl/core/scr_pkg.sv @@
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants of the sensor channel remap
// Belt sizes, layout codes, stage words and the sub-block reorder table.
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int SENSOR_COUNT     = 1152;
    localparam int FIRST_BELT_SIZE  = 864;
    localparam int SECOND_BELT_SIZE = SENSOR_COUNT - FIRST_BELT_SIZE;
    localparam int FIRST_OFFSET     = 288;
    localparam int SECOND_OFFSET    = 96;
    localparam int BLOCK_COUNT      = SENSOR_COUNT / 32;

    localparam logic [1:0] MODE_BYPASS  = 2'd0;
    localparam logic [1:0] MODE_BARREL  = 2'd1;
    localparam logic [1:0] MODE_DEFAULT = 2'd2;

    typedef struct packed {
        logic [9:0] t;
        logic       sec;
        logic [1:0] mode;
    } t_s1;

    typedef struct packed {
        logic [9:0] t;
        logic [7:0] q;
        logic       sec;
        logic [1:0] mode;
    } t_s2;

    typedef struct packed {
        logic [10:0] k;
        logic        sec;
        logic [1:0]  mode;
    } t_s3;

    typedef logic [63:0][5:0] t_jtab;

    function automatic t_jtab build_jtab();
        t_jtab tab;
        int    blk;
        int    sub;
        for (int j = 0; j < 64; j++) begin
            if (j < BLOCK_COUNT) begin
                blk    = j / 6;
                sub    = j % 6;
                tab[j] = 6'(((blk / 2 + 1) % 3) * 12 + (blk % 2) * 6 + 5 - sub);
            end else begin
                tab[j] = '0;
            end
        end
        return tab;
    endfunction

    localparam t_jtab JTAB = build_jtab();

endpackage

@@ rtl/core/scr_front.sv @@
// ----------------------------------------------------------------------------
// scr_front: position wrap and belt slot stage
// Wraps the position, splits the belts and applies the default offsets.
// ----------------------------------------------------------------------------
module scr_front (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [10:0]   i_position,
    input  logic [1:0]    i_mode,
    output scr_pkg::t_s1  o_s1
);
    import scr_pkg::*;

    logic [10:0] p_w;
    logic        sec;
    logic [10:0] r;
    logic [10:0] t_f;
    logic [10:0] t_s;
    logic [1:0]  mode;
    t_s1         n_s1;
    t_s1         r_s1;

    always_comb begin
        p_w  = (i_position >= 11'(SENSOR_COUNT)) ? i_position - 11'(SENSOR_COUNT) : i_position;
        sec  = (p_w >= 11'(FIRST_BELT_SIZE));
        r    = p_w - 11'(FIRST_BELT_SIZE);
        mode = (i_mode == MODE_BYPASS || i_mode == MODE_BARREL) ? i_mode : MODE_DEFAULT;
        t_f  = p_w + 11'(FIRST_OFFSET);
        if (t_f >= 11'(FIRST_BELT_SIZE)) begin
            t_f = t_f - 11'(FIRST_BELT_SIZE);
        end
        t_s  = r + 11'(SECOND_OFFSET);
        if (t_s >= 11'(SECOND_BELT_SIZE)) begin
            t_s = t_s - 11'(SECOND_BELT_SIZE);
        end
        n_s1.sec  = sec;
        n_s1.mode = mode;
        if (mode == MODE_DEFAULT) begin
            n_s1.t = sec ? t_s[9:0] : t_f[9:0];
        end else begin
            n_s1.t = sec ? r[9:0] : p_w[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

@@ rtl/core/scr_div3.sv @@
// ----------------------------------------------------------------------------
// scr_div3: group quotient stage
// Divides the scaled belt slot by three with a reciprocal multiply.
// ----------------------------------------------------------------------------
module scr_div3 (
    input  logic          i_clk,
    input  logic          i_en,
    input  scr_pkg::t_s1  i_s1,
    output scr_pkg::t_s2  o_s2
);
    import scr_pkg::*;

    logic [8:0]  x;
    logic [18:0] prod;
    t_s2         n_s2;
    t_s2         r_s2;

    always_comb begin
        x         = (i_s1.mode == MODE_BARREL) ? i_s1.t[9:1] : {1'b0, i_s1.t[9:2]};
        prod      = {10'b0, x} * 19'd683;
        n_s2.t    = i_s1.t;
        n_s2.q    = prod[18:11];
        n_s2.sec  = i_s1.sec;
        n_s2.mode = i_s1.mode;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

@@ rtl/core/scr_index.sv @@
// ----------------------------------------------------------------------------
// scr_index: sensor index assembly stage
// Spreads the belt slot over the sensor groups.
// ----------------------------------------------------------------------------
module scr_index (
    input  logic          i_clk,
    input  logic          i_en,
    input  scr_pkg::t_s2  i_s2,
    output scr_pkg::t_s3  o_s3
);
    import scr_pkg::*;

    t_s3 n_s3;
    t_s3 r_s3;

    always_comb begin
        n_s3.sec  = i_s2.sec;
        n_s3.mode = i_s2.mode;
        if (i_s2.sec) begin
            if (i_s2.mode == MODE_BARREL) begin
                n_s3.k = {i_s2.t[8:1], 2'b11, i_s2.t[0]};
            end else begin
                n_s3.k = {i_s2.t[8:2], 2'b11, i_s2.t[1:0]};
            end
        end else begin
            if (i_s2.mode == MODE_BARREL) begin
                n_s3.k = {1'b0, i_s2.t} + {2'b0, i_s2.q, 1'b0};
            end else begin
                n_s3.k = {1'b0, i_s2.t} + {1'b0, i_s2.q, 2'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

@@ rtl/core/sensor_channel_remap.sv @@
// ----------------------------------------------------------------------------
// sensor_channel_remap: position to source index map of the sensor table
// Maps a 1152-entry table position to the sensor index of the chosen layout.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry one position word.
// Output channel: o_out_valid / i_out_ready carry source index and belt flag.
// A word moves at a rising edge with valid and ready both high.
// Each accepted word goes through every stage register to the output; one word is
// taken every cycle while the receiver keeps i_out_ready high. The four
// stages are wrap and belt offset, reciprocal multiply by three, group
// spread, and the sub-block reorder table of layout 0.
// When the receiver stalls, each stage holds its word and bubbles close up;
// o_in_ready falls only once all four stages hold a word.
// i_cfg_we writes the layout code from i_cfg_data; words accepted after the
// write use the new code, so write only while idle; code 3 acts as the
// default layout.
// Reset empties the pipeline and sets the layout to the default, code 2.
// ----------------------------------------------------------------------------
module sensor_channel_remap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [10:0] i_position,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [10:0] o_source_index,
    output logic        o_second_belt
);
    import scr_pkg::*;

    logic [1:0]  r_mode;
    logic [3:0]  r_vld;
    logic [3:0]  en;
    t_s1         s1;
    t_s2         s2;
    t_s3         s3;
    logic [10:0] n_index;
    logic [10:0] r_index;
    logic        r_sec;

    always_comb begin
        en[3] = !r_vld[3] || i_out_ready;
        en[2] = !r_vld[2] || en[3];
        en[1] = !r_vld[1] || en[2];
        en[0] = !r_vld[0] || en[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DEFAULT;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            if (en[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (en[2]) begin
                r_vld[2] <= r_vld[1];
            end
            if (en[3]) begin
                r_vld[3] <= r_vld[2];
            end
        end
    end

    scr_front u_front (
        .i_clk      (i_clk),
        .i_en       (en[0]),
        .i_position (i_position),
        .i_mode     (r_mode),
        .o_s1       (s1)
    );

    scr_div3 u_div3 (
        .i_clk (i_clk),
        .i_en  (en[1]),
        .i_s1  (s1),
        .o_s2  (s2)
    );

    scr_index u_index (
        .i_clk (i_clk),
        .i_en  (en[2]),
        .i_s2  (s2),
        .o_s3  (s3)
    );

    always_comb begin
        if (s3.mode == MODE_BYPASS) begin
            n_index = {JTAB[s3.k[10:5]], s3.k[4:0]};
        end else begin
            n_index = s3.k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_index <= n_index;
            r_sec   <= s3.sec;
        end
    end

    assign o_in_ready     = en[0];
    assign o_out_valid    = r_vld[3];
    assign o_source_index = r_index;
    assign o_second_belt  = r_sec;

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_source_index < 11'(SENSOR_COUNT)))
        else $error("source index beyond sensor table");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_vld == 4'hF) && !i_out_ready)
        else $error("input stalled with a free stage");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word not held in first stage");

endmodule

@@ test/scr_remap_checker.sv @@
// ----------------------------------------------------------------------------
// scr_remap_checker: scoreboard of the sensor channel remap
// Tracks the layout register from the write port, maps every accepted
// position word to its source index and belt flag, and compares each
// accepted output word against the oldest predicted mapping.
// ----------------------------------------------------------------------------
module scr_remap_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [10:0] i_position,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [10:0] i_source_index,
    input  logic        i_second_belt,
    output int          o_fail_count,
    output int          o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import scr_pkg::*;

    localparam int unsigned GROUP_SPAN       = 16;
    localparam int unsigned FIRST_PER_GROUP  = 12;
    localparam int unsigned SECOND_PER_GROUP = 4;
    localparam int unsigned SUPER_SPAN       = 192;
    localparam int unsigned SUB_SPAN         = 32;
    localparam int unsigned SUBS_PER_SUPER   = 6;
    localparam int unsigned ROT_SPAN         = 384;
    localparam int unsigned ROT_BLOCKS       = 3;
    localparam int unsigned BARREL_SPAN      = 8;
    localparam int unsigned BARREL_FIRST     = 6;
    localparam int unsigned BARREL_SECOND    = 2;

    typedef struct packed {
        logic [10:0] position;
        logic [10:0] source_index;
        logic        second_belt;
    } t_remap_word;

    function automatic int unsigned spread_first(int unsigned t);
        return (t / FIRST_PER_GROUP) * GROUP_SPAN + (t % FIRST_PER_GROUP);
    endfunction

    function automatic int unsigned spread_second(int unsigned t);
        return (t / SECOND_PER_GROUP) * GROUP_SPAN + FIRST_PER_GROUP
            + (t % SECOND_PER_GROUP);
    endfunction

    function automatic t_remap_word remap_position(logic [1:0] mode, logic [10:0] pos);
        t_remap_word w;
        int unsigned p;
        int unsigned k;
        int unsigned m;
        int unsigned src;
        p = pos;
        if (p >= SENSOR_COUNT) begin
            p = p - SENSOR_COUNT;
        end
        unique case (mode)
            MODE_BYPASS: begin
                if (p < FIRST_BELT_SIZE) begin
                    k = spread_first(p);
                end else begin
                    k = spread_second(p - FIRST_BELT_SIZE);
                end
                k = k % SENSOR_COUNT;
                m = (k / SUPER_SPAN) * SUPER_SPAN
                    + (SUBS_PER_SUPER - 1 - (k % SUPER_SPAN) / SUB_SPAN) * SUB_SPAN
                    + (k % SUB_SPAN);
                src = (((m / ROT_SPAN) + 1) % ROT_BLOCKS) * ROT_SPAN + (m % ROT_SPAN);
            end
            MODE_BARREL: begin
                if (p < FIRST_BELT_SIZE) begin
                    src = (p / BARREL_FIRST) * BARREL_SPAN + (p % BARREL_FIRST);
                end else begin
                    k = p - FIRST_BELT_SIZE;
                    src = BARREL_FIRST + (k / BARREL_SECOND) * BARREL_SPAN
                        + (k % BARREL_SECOND);
                end
            end
            default: begin
                if (p < FIRST_BELT_SIZE) begin
                    src = spread_first((p + FIRST_OFFSET) % FIRST_BELT_SIZE);
                end else begin
                    src = spread_second((p - FIRST_BELT_SIZE + SECOND_OFFSET)
                        % SECOND_BELT_SIZE);
                end
            end
        endcase
        w.position     = pos;
        w.source_index = 11'(src);
        w.second_belt  = (p >= FIRST_BELT_SIZE);
        return w;
    endfunction

    logic [1:0]  layout;
    t_remap_word expected_maps[$];
    int          fails;

    always @(posedge i_clk) begin : watch
        t_remap_word want;
        if (!i_rst_n) begin
            layout = MODE_DEFAULT;
            expected_maps.delete();
            fails = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_maps.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual index %0d belt %0b",
                             $time, i_source_index, i_second_belt);
                    fails++;
                end else begin
                    want = expected_maps.pop_front();
                    if (i_source_index !== want.source_index) begin
                        $display("%0t: position %0d source_index expected %0d actual %0d",
                                 $time, want.position, want.source_index, i_source_index);
                        fails++;
                    end
                    if (i_second_belt !== want.second_belt) begin
                        $display("%0t: position %0d second_belt expected %0b actual %0b",
                                 $time, want.position, want.second_belt, i_second_belt);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_maps.push_back(remap_position(layout, i_position));
            end
            if (i_cfg_we) begin
                layout = i_cfg_data;
            end
        end
        o_fail_count    <= fails;
        o_pending_count <= expected_maps.size();
    end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: regression of the sensor channel remap
// Drives position words through every layout code, belt edges and
// out-of-range positions first, then random words with idle gaps on both
// sides, one calm phase and one long receiver hold-off; the checker predicts
// and compares every output word.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scr_pkg::*;

    localparam logic [1:0] MODE_UNDEFINED = 2'd3;
    localparam int RESET_CYCLES   = 11;
    localparam int PHASE_WORDS    = 216;
    localparam int SETTLE_CYCLES  = 6;
    localparam int TAIL_CYCLES    = 16;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 1000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_data  = MODE_DEFAULT;
    logic        i_in_valid  = 1'b0;
    logic [10:0] i_position  = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [10:0] o_source_index;
    logic        o_second_belt;

    logic calm      = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   words_in  = 0;
    int   quiet     = 0;
    int   fail_count;
    int   pending_count;

    always #4 i_clk = ~i_clk;

    sensor_channel_remap i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_source_index (o_source_index),
        .o_second_belt  (o_second_belt)
    );

    scr_remap_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_position      (i_position),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_source_index  (o_source_index),
        .i_second_belt   (o_second_belt),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            words_in <= words_in + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [10:0] pick_position();
        logic [10:0] edges[10] = '{11'd0, 11'd575, 11'd576, 11'd863, 11'd864,
                                   11'd1055, 11'd1056, 11'd1151, 11'd1152, 11'd2047};
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 11'($urandom_range(0, SENSOR_COUNT - 1));
        end else if (roll < 82) begin
            return 11'(int'(edges[$urandom_range(0, 9)]) + $urandom_range(0, 2) - 1);
        end
        return 11'($urandom_range(SENSOR_COUNT, 2047));
    endfunction

    task automatic send_position(input logic [10:0] pos);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 20) begin
                gap++;
            end
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_position <= pos;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_layout(input logic [1:0] mode);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [1:0]  edge_modes[4]  = '{MODE_DEFAULT, MODE_BYPASS, MODE_BARREL,
                                        MODE_UNDEFINED};
        logic [10:0] edge_points[6] = '{11'd0, 11'd863, 11'd864, 11'd1151,
                                        11'd1152, 11'd2047};
        logic [1:0]  phase_modes[6] = '{MODE_BYPASS, MODE_BARREL, MODE_DEFAULT,
                                        MODE_UNDEFINED, MODE_BYPASS, MODE_DEFAULT};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset layout first, then each other code written in turn
        for (int m = 0; m < 4; m++) begin
            if (m > 0) begin
                set_layout(edge_modes[m]);
            end
            foreach (edge_points[j]) begin
                send_position(edge_points[j]);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            set_layout(phase_modes[ph]);
            calm <= (ph == 2);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_position(pick_position());
            end
        end
        calm <= 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/scr_pkg.sv
rtl/core/scr_front.sv
rtl/core/scr_div3.sv
rtl/core/scr_index.sv
rtl/core/sensor_channel_remap.sv
test/scr_remap_checker.sv
test/tb.sv
